@@ design/dss_pkg.sv @@
// types, state and command codes and the step table of the drive state stepper
`default_nettype none
package dss_pkg;

  typedef enum logic [2:0] {
    ST_NOT_READY      = 3'd0,
    ST_DISABLED       = 3'd1,
    ST_READY          = 3'd2,
    ST_SWITCHED_ON    = 3'd3,
    ST_ENABLED        = 3'd4,
    ST_QUICK_STOP     = 3'd5,
    ST_FAULT_REACTION = 3'd6,
    ST_FAULT          = 3'd7
  } drive_state_e;

  typedef enum logic [2:0] {
    CMD_NONE            = 3'd0,
    CMD_SHUTDOWN        = 3'd1,
    CMD_SWITCH_ON       = 3'd2,
    CMD_ENABLE_OP       = 3'd3,
    CMD_DISABLE_OP      = 3'd4,
    CMD_DISABLE_VOLTAGE = 3'd5
  } command_e;

  typedef struct packed {
    logic [15:0] status_word;
    logic [2:0]  required_state;
  } dss_in_t;

  typedef struct packed {
    logic [2:0]  current_state;
    logic        state_known;
    logic [2:0]  next_state;
    logic [2:0]  command_sent;
    logic [15:0] control_word;
  } dss_out_t;

  // row: current state, column: required state
  localparam logic [2:0] STEP_TABLE [0:7][0:7] = '{
    '{3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0},
    '{3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1},
    '{3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2},
    '{3'd3, 3'd2, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3},
    '{3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd4, 3'd4},
    '{3'd5, 3'd1, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5},
    '{3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd7},
    '{3'd7, 3'd1, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7}
  };

endpackage
`default_nettype wire

@@ design/drive_state_stepper.sv @@
// top level: item register, step logic, result register and kept control word
// an accepted item waits in the item register until the result register is free, then is stepped and registered
// throughput: one item per cycle while the result stage is not stalled; the control word register is the only loop
// reset: both stages empty, control word cleared to zero
// stall on the input follows the result stage only when both stages are full
`default_nettype none
module drive_state_stepper (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire dss_pkg::dss_in_t  in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dss_pkg::dss_out_t      out_item_o
);

  logic              in_valid_q;
  dss_pkg::dss_in_t  in_item_q;
  logic              out_valid_q;
  dss_pkg::dss_out_t out_item_q;
  logic [15:0]       cw_q;
  dss_pkg::dss_out_t step_result;
  logic              out_free;
  logic              move;
  logic              in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign move       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  dss_step u_step (
    .item_i   (in_item_q),
    .cw_i     (cw_q),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cw_q        <= 16'h0000;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (move) begin
        in_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
        cw_q        <= step_result.control_word;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (move) begin
      out_item_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_unknown_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.state_known) |->
      (out_item_q.command_sent == dss_pkg::CMD_NONE &&
       out_item_q.next_state == dss_pkg::ST_NOT_READY))
    else $error("unknown status word produced a command or next state");

  a_cmd_clears_b7: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.command_sent != dss_pkg::CMD_NONE) |->
      !out_item_q.control_word[7])
    else $error("command left control word bit 7 set");

  a_cw_only_on_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> $stable(cw_q))
    else $error("control word changed without an item passing");

  a_result_cw_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> (out_item_q.control_word == cw_q))
    else $error("result control word differs from kept control word");

  a_reached_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.current_state == out_item_q.next_state) |->
      out_item_q.command_sent == dss_pkg::CMD_NONE)
    else $error("command issued with no state change");

endmodule
`default_nettype wire

@@ design/dss_step.sv @@
// status decode, table step, command select and control word update for one item
`default_nettype none
module dss_step (
  input  wire dss_pkg::dss_in_t  item_i,
  input  wire logic [15:0]       cw_i,
  output dss_pkg::dss_out_t      result_o
);

  logic                  b0, b1, b2, b3, b5, b6;
  logic                  known;
  dss_pkg::drive_state_e cur;
  dss_pkg::drive_state_e nxt;
  dss_pkg::command_e     cmd;
  logic [15:0]           cw_new;

  assign b0 = item_i.status_word[0];
  assign b1 = item_i.status_word[1];
  assign b2 = item_i.status_word[2];
  assign b3 = item_i.status_word[3];
  assign b5 = item_i.status_word[5];
  assign b6 = item_i.status_word[6];

  // first matching pattern wins
  always_comb begin
    known = 1'b1;
    cur   = dss_pkg::ST_NOT_READY;
    if (!b6 && !b3 && !b2 && !b1 && !b0) begin
      cur = dss_pkg::ST_NOT_READY;
    end else if (b6 && !b3 && !b2 && !b1 && !b0) begin
      cur = dss_pkg::ST_DISABLED;
    end else if (!b6 && b5 && !b3 && !b2 && !b1 && b0) begin
      cur = dss_pkg::ST_READY;
    end else if (!b6 && b5 && !b3 && !b2 && b1 && b0) begin
      cur = dss_pkg::ST_SWITCHED_ON;
    end else if (!b6 && b5 && !b3 && b2 && b1 && b0) begin
      cur = dss_pkg::ST_ENABLED;
    end else if (!b6 && !b5 && !b3 && b2 && b1 && b0) begin
      cur = dss_pkg::ST_QUICK_STOP;
    end else if (!b6 && b3 && b2 && b1 && b0) begin
      cur = dss_pkg::ST_FAULT_REACTION;
    end else if (!b6 && b3 && !b2 && !b1 && !b0) begin
      cur = dss_pkg::ST_FAULT;
    end else begin
      known = 1'b0;
    end
  end

  always_comb begin
    nxt = dss_pkg::ST_NOT_READY;
    cmd = dss_pkg::CMD_NONE;
    if (known) begin
      nxt = dss_pkg::drive_state_e'(dss_pkg::STEP_TABLE[cur][item_i.required_state]);
      if (cur == dss_pkg::ST_DISABLED && nxt == dss_pkg::ST_READY) begin
        cmd = dss_pkg::CMD_SHUTDOWN;
      end else if (cur == dss_pkg::ST_READY && nxt == dss_pkg::ST_SWITCHED_ON) begin
        cmd = dss_pkg::CMD_SWITCH_ON;
      end else if (cur == dss_pkg::ST_SWITCHED_ON && nxt == dss_pkg::ST_ENABLED) begin
        cmd = dss_pkg::CMD_ENABLE_OP;
      end else if (cur == dss_pkg::ST_ENABLED && nxt == dss_pkg::ST_SWITCHED_ON) begin
        cmd = dss_pkg::CMD_DISABLE_OP;
      end else if (cur == dss_pkg::ST_SWITCHED_ON && nxt == dss_pkg::ST_READY) begin
        cmd = dss_pkg::CMD_DISABLE_VOLTAGE;
      end
    end
  end

  always_comb begin
    unique case (cmd)
      dss_pkg::CMD_SHUTDOWN:        cw_new = (cw_i & ~16'h0081) | 16'h0006;
      dss_pkg::CMD_SWITCH_ON:       cw_new = (cw_i & ~16'h0088) | 16'h0007;
      dss_pkg::CMD_ENABLE_OP:       cw_new = (cw_i & ~16'h0080) | 16'h000F;
      dss_pkg::CMD_DISABLE_OP:      cw_new = (cw_i & ~16'h0088) | 16'h0007;
      dss_pkg::CMD_DISABLE_VOLTAGE: cw_new = cw_i & ~16'h0082;
      default:                      cw_new = cw_i;
    endcase
  end

  always_comb begin
    result_o.current_state = cur;
    result_o.state_known   = known;
    result_o.next_state    = nxt;
    result_o.command_sent  = cmd;
    result_o.control_word  = cw_new;
  end

endmodule
`default_nettype wire
